@@ rtl/huff_pkg.sv @@
// Package for the Huffman code builder: sizes, status codes, datapath
// operation codes and the command and status structs that join the controller and datapath.
// It depends on nothing.
`timescale 1ns / 1ps

package huff_pkg;

    localparam int MAX_SYMBOLS  = 64;
    localparam int MAX_CODE_LEN = 32;
    localparam int WEIGHT_BITS  = 24;

    localparam int SYM_W   = 8;
    localparam int WIN_W   = 24;
    localparam int IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int SUM_W   = WEIGHT_BITS + IDX_W;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int ST_W    = 2;
    localparam int ENTRY_W = CODE_W + LEN_W;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_LONG     = 2'd1;
    localparam logic [ST_W-1:0] ST_UNSORTED = 2'd2;
    localparam logic [ST_W-1:0] ST_TOO_MANY = 2'd3;

    // Operation that the datapath carries out in the current cycle.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_START,
        OP_M_RD1,
        OP_M_RD2,
        OP_M_SUM,
        OP_M_CMP,
        OP_M_INS,
        OP_E_INIT,
        OP_E_RDP,
        OP_E_RDC,
        OP_E_GETS,
        OP_E_SHIFT,
        OP_E_W1,
        OP_E_W2,
        OP_O_RD,
        OP_O_LD,
        OP_O_WAIT,
        OP_O_NEXT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    // Conditions that the datapath reports back to the controller.
    typedef struct packed {
        logic in_last;
        logic err;
        logic single;
        logic two;
        logic cmp_le;
        logic i_one;
        logic m_two;
        logic m_final;
        logic shift_first;
        logic shift_more;
        logic eot;
    } t_stat;

endpackage

@@ rtl/huff_if.sv @@
// Handshake channels of the Huffman code builder: input item and result item.
// Depends on huff_pkg.
`timescale 1ns / 1ps

interface huff_in_if
    import huff_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic [WIN_W-1:0] weight;
    logic             last;

    modport source (output valid, output symbol, output weight, output last, input ready);
    modport sink   (input valid, input symbol, input weight, input last, output ready);
endinterface

interface huff_out_if
    import huff_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  out_symbol;
    logic [CODE_W-1:0] codeword;
    logic [LEN_W-1:0]  code_length;
    logic [ST_W-1:0]   status;
    logic              end_of_table;

    modport source (output valid, output out_symbol, output codeword, output code_length,
                    output status, output end_of_table, input ready);
    modport sink   (input valid, input out_symbol, input codeword, input code_length,
                    input status, input end_of_table, output ready);
endinterface

@@ rtl/huff_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module huff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/huff_ctrl.sv @@
// Controller of the Huffman code builder: sequences load, merge, expansion and output.
// Depends on huff_pkg.
`timescale 1ns / 1ps

module huff_ctrl
    import huff_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_M_RD1   = 5'd2;
    localparam logic [4:0] S_M_RD2   = 5'd3;
    localparam logic [4:0] S_M_SUM   = 5'd4;
    localparam logic [4:0] S_M_CMP   = 5'd5;
    localparam logic [4:0] S_M_INS   = 5'd6;
    localparam logic [4:0] S_E_INIT  = 5'd7;
    localparam logic [4:0] S_E_RDP   = 5'd8;
    localparam logic [4:0] S_E_RDC   = 5'd9;
    localparam logic [4:0] S_E_GETS  = 5'd10;
    localparam logic [4:0] S_E_SHIFT = 5'd11;
    localparam logic [4:0] S_E_W1    = 5'd12;
    localparam logic [4:0] S_E_W2    = 5'd13;
    localparam logic [4:0] S_O_RD    = 5'd14;
    localparam logic [4:0] S_O_LD    = 5'd15;
    localparam logic [4:0] S_O_WAIT  = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       in_fire;
    logic       out_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_O_WAIT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    // Next state and datapath operation.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.op = OP_LOAD;
                    if (i_stat.in_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.op = OP_START;
                // Two symbols need no merge and go straight to the base codes.
                if (i_stat.err || i_stat.single) begin
                    n_state = S_O_RD;
                end else if (i_stat.two) begin
                    n_state = S_E_INIT;
                end else begin
                    n_state = S_M_RD1;
                end
            end
            S_M_RD1: begin
                o_cmd.op = OP_M_RD1;
                n_state  = S_M_RD2;
            end
            S_M_RD2: begin
                o_cmd.op = OP_M_RD2;
                n_state  = S_M_SUM;
            end
            S_M_SUM: begin
                o_cmd.op = OP_M_SUM;
                n_state  = S_M_CMP;
            end
            S_M_CMP: begin
                o_cmd.op = OP_M_CMP;
                if (!i_stat.cmp_le || i_stat.i_one) begin
                    n_state = S_M_INS;
                end
            end
            S_M_INS: begin
                o_cmd.op = OP_M_INS;
                n_state  = i_stat.m_two ? S_E_INIT : S_M_RD1;
            end
            S_E_INIT: begin
                o_cmd.op = OP_E_INIT;
                n_state  = i_stat.two ? S_O_RD : S_E_RDP;
            end
            S_E_RDP: begin
                o_cmd.op = OP_E_RDP;
                n_state  = S_E_RDC;
            end
            S_E_RDC: begin
                o_cmd.op = OP_E_RDC;
                n_state  = S_E_GETS;
            end
            S_E_GETS: begin
                o_cmd.op = OP_E_GETS;
                n_state  = i_stat.shift_first ? S_E_SHIFT : S_E_W1;
            end
            S_E_SHIFT: begin
                o_cmd.op = OP_E_SHIFT;
                n_state  = i_stat.shift_more ? S_E_SHIFT : S_E_W1;
            end
            S_E_W1: begin
                o_cmd.op = OP_E_W1;
                n_state  = S_E_W2;
            end
            S_E_W2: begin
                o_cmd.op = OP_E_W2;
                n_state  = i_stat.m_final ? S_O_RD : S_E_RDP;
            end
            S_O_RD: begin
                o_cmd.op = OP_O_RD;
                n_state  = S_O_LD;
            end
            S_O_LD: begin
                o_cmd.op = OP_O_LD;
                n_state  = S_O_WAIT;
            end
            S_O_WAIT: begin
                if (out_fire) begin
                    o_cmd.op = OP_O_NEXT;
                    n_state  = i_stat.eot ? S_IDLE : S_O_RD;
                end else begin
                    o_cmd.op = OP_O_WAIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/huff_dpath.sv @@
// Datapath of the Huffman code builder: weight, symbol, code and merge tables,
// index counters and the result register. Depends on huff_pkg and huff_ram.
`timescale 1ns / 1ps

module huff_dpath
    import huff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [WIN_W-1:0]  i_weight,
    input  logic              i_last,
    output t_stat             o_stat,
    output logic [SYM_W-1:0]  o_out_symbol,
    output logic [CODE_W-1:0] o_codeword,
    output logic [LEN_W-1:0]  o_code_length,
    output logic [ST_W-1:0]   o_status,
    output logic              o_end_of_table
);

    logic [CNT_W-1:0]       r_cnt;
    logic [ST_W-1:0]        r_err;
    logic [WEIGHT_BITS-1:0] r_prev_w;
    logic [CNT_W-1:0]       r_n;
    logic [ST_W-1:0]        r_status;
    logic [IDX_W-1:0]       r_m;
    logic [IDX_W-1:0]       r_i;
    logic [IDX_W-1:0]       r_j;
    logic [IDX_W-1:0]       r_k;
    logic [SUM_W-1:0]       r_q;
    logic [CODE_W-1:0]      r_s;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       r_maxlen;
    logic [SYM_W-1:0]       r_o_symbol;
    logic [CODE_W-1:0]      r_o_code;
    logic [LEN_W-1:0]       r_o_len;
    logic [ST_W-1:0]        r_o_status;
    logic                   r_o_eot;

    logic [WEIGHT_BITS-1:0] wt;
    logic                   full;
    logic [ST_W-1:0]        ld_err;
    logic [CNT_W-1:0]       ld_cnt;
    logic [IDX_W-1:0]       n_last;
    logic [SUM_W-1:0]       sum;
    logic [LEN_W-1:0]       len_inc;
    logic [ST_W-1:0]        fin_status;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [SUM_W-1:0]       w_wdata;
    logic [IDX_W-1:0]       w_raddr;
    logic [SUM_W-1:0]       w_rdata;
    logic                   s_we;
    logic [SYM_W-1:0]       s_rdata;
    logic                   c_we;
    logic [IDX_W-1:0]       c_waddr;
    logic [ENTRY_W-1:0]     c_wdata;
    logic [IDX_W-1:0]       c_raddr;
    logic [ENTRY_W-1:0]     c_rdata;
    logic                   p_we;
    logic [IDX_W-1:0]       p_rdata;

    // Load bookkeeping: order check, overflow and symbol count.
    assign wt     = WEIGHT_BITS'(i_weight);
    assign full   = (r_cnt == CNT_W'(MAX_SYMBOLS));
    assign ld_cnt = full ? r_cnt : r_cnt + CNT_W'(1);
    always_comb begin
        if (full) begin
            ld_err = ST_TOO_MANY;
        end else if (r_cnt != '0 && wt > r_prev_w && r_err == ST_OK) begin
            ld_err = ST_UNSORTED;
        end else begin
            ld_err = r_err;
        end
    end

    assign n_last     = IDX_W'(r_n - CNT_W'(1));
    assign sum        = r_q + w_rdata;
    assign len_inc    = r_len + LEN_W'(1);
    assign fin_status = (r_status == ST_OK && r_maxlen > LEN_W'(MAX_CODE_LEN))
                        ? ST_LONG : r_status;

    // Status to the controller.
    assign o_stat.in_last     = i_last;
    assign o_stat.err         = (r_status != ST_OK);
    assign o_stat.single      = (r_n == CNT_W'(1));
    assign o_stat.two         = (r_n == CNT_W'(2));
    assign o_stat.cmp_le      = (w_rdata <= r_q);
    assign o_stat.i_one       = (r_i == IDX_W'(1));
    assign o_stat.m_two       = (r_m == IDX_W'(2));
    assign o_stat.m_final     = (r_m == n_last);
    assign o_stat.shift_first = ({1'b0, r_j} + CNT_W'(2)) <= {1'b0, r_m};
    assign o_stat.shift_more  = ({1'b0, r_i} + CNT_W'(3)) <= {1'b0, r_m};
    assign o_stat.eot         = (r_k == n_last);

    // Weight table ports: load, shift during insertion, and the merged sum.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[IDX_W-1:0];
        w_wdata = SUM_W'(wt);
        w_raddr = '0;
        case (i_cmd.op)
            OP_LOAD: begin
                w_we = !full;
            end
            OP_M_RD1: begin
                w_raddr = r_m - IDX_W'(1);
            end
            OP_M_RD2: begin
                w_raddr = r_m;
            end
            OP_M_SUM: begin
                w_raddr = r_m - IDX_W'(2);
            end
            OP_M_CMP: begin
                w_we    = o_stat.cmp_le;
                w_waddr = r_i;
                w_wdata = w_rdata;
                w_raddr = r_i - IDX_W'(2);
            end
            OP_M_INS: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_q;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign s_we = (i_cmd.op == OP_LOAD) && !full;
    assign p_we = (i_cmd.op == OP_M_INS);

    // Code table ports: base codes, shift down, and the two split children.
    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_m;
        c_wdata = {r_s << 1, len_inc};
        c_raddr = r_k;
        case (i_cmd.op)
            OP_START: begin
                c_we    = 1'b1;
                c_waddr = '0;
                c_wdata = {CODE_W'(0), LEN_W'(1)};
            end
            OP_E_INIT: begin
                c_we    = 1'b1;
                c_waddr = IDX_W'(1);
                c_wdata = {CODE_W'(1), LEN_W'(1)};
            end
            OP_E_RDC: begin
                c_raddr = p_rdata;
            end
            OP_E_GETS: begin
                c_raddr = r_j + IDX_W'(1);
            end
            OP_E_SHIFT: begin
                c_we    = 1'b1;
                c_waddr = r_i;
                c_wdata = c_rdata;
                c_raddr = r_i + IDX_W'(2);
            end
            OP_E_W1: begin
                c_we    = 1'b1;
                c_waddr = r_m - IDX_W'(1);
            end
            OP_E_W2: begin
                c_we    = 1'b1;
                c_wdata = {(r_s << 1) | CODE_W'(1), len_inc};
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    huff_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SYMBOLS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    huff_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_symbol_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (r_k),
        .o_rdata (s_rdata)
    );

    huff_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SYMBOLS)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    huff_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SYMBOLS)) u_merge_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_m),
        .i_wdata (r_j),
        .i_raddr (r_m),
        .o_rdata (p_rdata)
    );

    // Load count and error flag; these return to zero after each table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= ST_OK;
        end else if (i_cmd.op == OP_LOAD) begin
            if (i_last) begin
                r_cnt <= '0;
                r_err <= ST_OK;
            end else begin
                r_cnt <= ld_cnt;
                r_err <= ld_err;
            end
        end
    end

    // Working registers of the build and the result register.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_prev_w <= wt;
                r_n      <= ld_cnt;
                r_status <= ld_err;
            end
            OP_START: begin
                r_maxlen <= LEN_W'(1);
                r_m      <= n_last;
                r_k      <= '0;
            end
            OP_M_RD2: begin
                r_q <= w_rdata;
            end
            OP_M_SUM: begin
                r_q <= sum;
                r_i <= r_m - IDX_W'(1);
            end
            OP_M_CMP: begin
                if (o_stat.cmp_le) begin
                    r_i <= r_i - IDX_W'(1);
                    if (o_stat.i_one) begin
                        r_j <= '0;
                    end
                end else begin
                    r_j <= r_i;
                end
            end
            OP_M_INS: begin
                r_m <= r_m - IDX_W'(1);
            end
            OP_E_INIT: begin
                r_m <= IDX_W'(2);
            end
            OP_E_RDC: begin
                r_j <= p_rdata;
            end
            OP_E_GETS: begin
                r_s   <= c_rdata[ENTRY_W-1:LEN_W];
                r_len <= c_rdata[LEN_W-1:0];
                r_i   <= r_j;
            end
            OP_E_SHIFT: begin
                r_i <= r_i + IDX_W'(1);
            end
            OP_E_W2: begin
                r_m <= r_m + IDX_W'(1);
                if (len_inc > r_maxlen) begin
                    r_maxlen <= len_inc;
                end
            end
            OP_O_LD: begin
                r_o_symbol <= s_rdata;
                r_o_status <= fin_status;
                r_o_eot    <= o_stat.eot;
                if (fin_status == ST_OK) begin
                    r_o_code <= c_rdata[ENTRY_W-1:LEN_W];
                    r_o_len  <= c_rdata[LEN_W-1:0];
                end else begin
                    r_o_code <= '0;
                    r_o_len  <= '0;
                end
            end
            OP_O_NEXT: begin
                r_k <= r_k + IDX_W'(1);
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out_symbol   = r_o_symbol;
    assign o_codeword     = r_o_code;
    assign o_code_length  = r_o_len;
    assign o_status       = r_o_status;
    assign o_end_of_table = r_o_eot;

endmodule

@@ rtl/huffman_code_builder_core.sv @@
// Top level of the Huffman code builder: controller plus datapath.
// Depends on huff_pkg, huff_if, huff_ctrl and huff_dpath.
//
//   channel  | dir | payload                                               | handshake
//   in_ch    | in  | symbol, weight, last                                  | valid/ready
//   out_ch   | out | out_symbol, codeword, code_length, status, end_of_table | valid/ready
//
// A non-final item is stored in the cycle that it is taken. The final item starts the build:
// the merge phase walks the weight table for each merge, up to the insert point, and the
// expansion walks the code table for each level, over the shift distance; both are bounded
// by the single read port of each table. Each result is then read from the tables and held
// on out_ch until it is taken; no item is taken meanwhile.
// Reset is synchronous and active low; the tables need no clearing.
`timescale 1ns / 1ps

module huffman_code_builder_core
    import huff_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    huff_in_if.sink   in_ch,
    huff_out_if.source out_ch
);

    t_cmd  cmd;
    t_stat stat;

    huff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    huff_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_symbol       (in_ch.symbol),
        .i_weight       (in_ch.weight),
        .i_last         (in_ch.last),
        .o_stat         (stat),
        .o_out_symbol   (out_ch.out_symbol),
        .o_codeword     (out_ch.codeword),
        .o_code_length  (out_ch.code_length),
        .o_status       (out_ch.status),
        .o_end_of_table (out_ch.end_of_table)
    );

endmodule

@@ rtl/huff_chk.sv @@
// Port-level checker for the Huffman code builder, bound to the top level.
// Depends on huff_pkg.
`timescale 1ns / 1ps

module huff_chk
    import huff_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CODE_W-1:0] i_codeword,
    input logic [LEN_W-1:0]  i_code_length,
    input logic [ST_W-1:0]   i_status
);

    // No item is taken while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // The final item closes the input until its table is delivered.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input still open after the final item");

    // An error result carries no code.
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_code_length == '0 && i_codeword == '0)
        else $error("error result with code bits");

    // A good result has a length between one and the limit.
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OK |->
        i_code_length != '0 && i_code_length <= LEN_W'(MAX_CODE_LEN))
        else $error("good result with bad length");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_codeword))
        else $error("stalled result changed");

endmodule

bind huffman_code_builder_core huff_chk u_huff_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (in_ch.valid),
    .i_in_ready    (in_ch.ready),
    .i_in_last     (in_ch.last),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_codeword    (out_ch.codeword),
    .i_code_length (out_ch.code_length),
    .i_status      (out_ch.status)
);

@@ sim/tb.sv @@
// Testbench for huffman_code_builder_core: sends symbol tables, predicts the
// Huffman codes of each table and checks every result item in order.
// Depends on huff_pkg, huff_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import huff_pkg::*;

    typedef struct {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [ST_W-1:0]   st;
        logic              eot;
    } t_code_item;

    localparam int LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    huff_in_if  in_ch ();
    huff_out_if out_ch ();

    huffman_code_builder_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: the table loaded so far.
    logic [WEIGHT_BITS-1:0] tbl_weight [MAX_SYMBOLS];
    logic [SYM_W-1:0]       tbl_sym [MAX_SYMBOLS];
    int                     tbl_count = 0;
    logic [ST_W-1:0]        tbl_err = ST_OK;

    t_code_item expected_codes [$];
    int  errors = 0;
    int  cycles = 0;
    bit  calm = 1'b0;
    int  hold_off = 0;

    // Merge the two smallest entries repeatedly, then expand codes back.
    task automatic predict_codes(input int n, output logic [63:0] code [MAX_SYMBOLS],
                                 output int len [MAX_SYMBOLS]);
        logic [63:0] w [MAX_SYMBOLS];
        int pos [MAX_SYMBOLS];
        logic [63:0] q;
        logic [63:0] s;
        int j;
        int l;
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            w[k] = (k < n) ? 64'(tbl_weight[k]) : 64'd0;
            code[k] = '0;
            len[k] = 0;
            pos[k] = 0;
        end
        code[0] = '0;
        len[0] = 1;
        if (n < 2) return;
        for (int m = n - 1; m >= 2; m--) begin
            q = w[m-1] + w[m];
            j = 0;
            for (int i = m - 1; i > 0; i--) begin
                if (w[i-1] <= q) begin
                    w[i] = w[i-1];
                end else begin
                    j = i;
                    break;
                end
            end
            w[j] = q;
            pos[m] = j;
        end
        code[1] = 64'd1;
        len[1] = 1;
        for (int m = 2; m < n; m++) begin
            j = pos[m];
            s = code[j];
            l = len[j];
            for (int i = j; i + 2 <= m; i++) begin
                code[i] = code[i+1];
                len[i] = len[i+1];
            end
            code[m-1] = s << 1;
            code[m] = (s << 1) | 64'd1;
            len[m-1] = l + 1;
            len[m] = l + 1;
        end
    endtask

    // Update the table for one accepted item and queue any results.
    task automatic absorb_item(input logic [SYM_W-1:0] sym, input logic [WIN_W-1:0] wt,
                               input logic last);
        logic [63:0] code [MAX_SYMBOLS];
        int len [MAX_SYMBOLS];
        logic [ST_W-1:0] st;
        t_code_item r;
        if (tbl_count < MAX_SYMBOLS) begin
            if (tbl_count > 0 && wt > tbl_weight[tbl_count-1] && tbl_err == ST_OK)
                tbl_err = ST_UNSORTED;
            tbl_weight[tbl_count] = wt;
            tbl_sym[tbl_count] = sym;
            tbl_count++;
        end else begin
            tbl_err = ST_TOO_MANY;
        end
        if (!last) return;
        st = tbl_err;
        if (st == ST_OK) begin
            predict_codes(tbl_count, code, len);
            for (int k = 0; k < tbl_count; k++)
                if (len[k] > MAX_CODE_LEN) st = ST_LONG;
        end
        for (int k = 0; k < tbl_count; k++) begin
            r.sym = tbl_sym[k];
            r.code = (st == ST_OK) ? code[k][31:0] : '0;
            r.len = (st == ST_OK) ? len[k][5:0] : '0;
            r.st = st;
            r.eot = (k + 1 == tbl_count);
            expected_codes = {expected_codes, r};
        end
        tbl_count = 0;
        tbl_err = ST_OK;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch %s got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Send one item, with random idle bursts before it.
    task automatic send_item(input logic [SYM_W-1:0] sym, input logic [WIN_W-1:0] wt,
                             input logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.symbol <= sym;
        in_ch.weight <= wt;
        in_ch.last   <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        absorb_item(sym, wt, last);
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_input();
        @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
    endtask

    // One sorted table of n symbols with weights up to wmax.
    task automatic send_sorted(input int n, input logic [WIN_W-1:0] wmax);
        logic [WIN_W-1:0] w;
        w = wmax;
        for (int k = 0; k < n; k++) begin
            send_item(SYM_W'($urandom_range(0, 255)), w, k == n - 1);
            w = WIN_W'($urandom_range(0, 32'(w)));
        end
    endtask

    task automatic test_directed();
        send_item(8'hA5, 24'd9, 1'b1);
        send_item(8'h00, 24'hFFFFFF, 1'b0);
        send_item(8'hFF, 24'hFFFFFF, 1'b1);
        send_item(8'h11, 24'd5, 1'b0);
        send_item(8'h22, 24'd0, 1'b0);
        send_item(8'h33, 24'd0, 1'b1);
        send_item(8'h44, 24'd3, 1'b0);
        send_item(8'h55, 24'd7, 1'b0);
        send_item(8'h66, 24'd1, 1'b1);
        send_item(8'h77, 24'd4, 1'b0);
        send_item(8'h88, 24'd2, 1'b0);
        send_item(8'h99, 24'd2, 1'b0);
        send_item(8'hAA, 24'd1, 1'b0);
        send_item(8'hBB, 24'd1, 1'b1);
        wait_drained();
    endtask

    // Fibonacci weights give a degenerate tree with codes longer than 32 bits.
    task automatic test_long_codes();
        logic [WIN_W-1:0] f [40];
        f[39] = WIN_W'(1);
        f[38] = WIN_W'(1);
        for (int k = 37; k >= 0; k--) f[k] = f[k+1] + f[k+2];
        for (int k = 0; k < 36; k++) send_item(SYM_W'(k), f[k+4], k == 35);
        wait_drained();
    endtask

    // Full table, then two too many.
    task automatic test_table_size();
        for (int k = 0; k < MAX_SYMBOLS; k++)
            send_item(SYM_W'(k), WIN_W'(MAX_SYMBOLS - k), k == MAX_SYMBOLS - 1);
        for (int k = 0; k < MAX_SYMBOLS + 2; k++)
            send_item(SYM_W'(k), 24'd10, k == MAX_SYMBOLS + 1);
        wait_drained();
    endtask

    // The output stalls for a long stretch while items keep coming.
    task automatic test_backpressure();
        hold_off = 300;
        send_sorted(8, 24'd1000);
        send_sorted(6, 24'd50);
        send_sorted(5, 24'd50);
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        for (int t = 0; t < 5; t++) begin
            calm = (t >= 4);
            n = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0: begin
                    for (int k = 0; k < n; k++)
                        send_item(SYM_W'($urandom), WIN_W'($urandom), k == n - 1);
                end
                1: send_sorted(n, WIN_W'($urandom_range(0, 3)));
                default: send_sorted(n, WIN_W'($urandom));
            endcase
            if (t == 2) wait_drained();
        end
        wait_drained();
    endtask

    // Output side: ready with random stalls, and check each result.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 4) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        t_code_item e;
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch("unexpected result", 64'(out_ch.out_symbol), 64'd0);
            end else begin
                e = expected_codes.pop_front();
                if (out_ch.out_symbol !== e.sym)
                    report_mismatch("out_symbol", 64'(out_ch.out_symbol), 64'(e.sym));
                if (out_ch.codeword !== e.code)
                    report_mismatch("codeword", 64'(out_ch.codeword), 64'(e.code));
                if (out_ch.code_length !== e.len)
                    report_mismatch("code_length", 64'(out_ch.code_length), 64'(e.len));
                if (out_ch.status !== e.st)
                    report_mismatch("status", 64'(out_ch.status), 64'(e.st));
                if (out_ch.end_of_table !== e.eot)
                    report_mismatch("end_of_table", 64'(out_ch.end_of_table), 64'(e.eot));
            end
        end
        if (cycles > LIMIT) begin
            $display("tb: timeout");
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid  <= 1'b0;
        in_ch.symbol <= '0;
        in_ch.weight <= '0;
        in_ch.last   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_codes();
        test_table_size();
        test_backpressure();
        test_random();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
